>>> design/mtds_pkg.sv
// shared constants, codes and controller/datapath interface types for the timer scheduler
package mtds_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FIRE_LIMIT = 16;
  localparam int FL_BITS    = $clog2(FIRE_LIMIT);
  localparam int CNT_BITS   = $clog2(FIRE_LIMIT + 1);
  localparam int GAP_BITS   = 8;
  localparam int GAP_RESET  = 5;

  // input word operation codes
  localparam logic [1:0] MODE_SCHED  = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_REINST = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_APPLY = 6'b000010,
    ST_PICK  = 6'b000100,
    ST_FIRE  = 6'b001000,
    ST_FIND  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan_clear;
    logic scan;
    logic find;
    logic fire;
    logic out_next;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic found;
    logic room;
    logic out_last;
  } dp_stat_t;

endpackage

>>> design/multi_timer_deadline_scheduler.sv
// top level of the multi-slot timer deadline scheduler
//
// Input channel (in_valid/in_stall) carries one word: mode, slot_id, time_value.
// Mode schedule writes a slot deadline (0 cancels), mode tick sets the current
// time and expires due slots, mode reinstate re-arms a slot no earlier than
// current time plus min_rearm_gap. Output channel (out_valid/out_stall) gives
// one result word per expired slot in deadline order (lower slot on ties), or a
// single status word when nothing expires; last marks the final word.
// Words are handled one at a time: in_stall is high from acceptance until the
// final result word is taken. The deadline table is walked by one shared
// compare unit, one slot per cycle. A schedule or reinstate runs one scan for
// the earliest deadline before its result is offered. A tick runs a full scan
// for each expiry, then one more that finds none unless the fire limit is
// reached, then the earliest-deadline scan, and offers its result words in
// turn. While the receiver stalls, the result word holds and the block waits.
// Reset (rst, synchronous) clears every slot, the current time and the earliest
// deadline, and sets min_rearm_gap to 5; cfg_we writes it.
module multi_timer_deadline_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  min_rearm_gap,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  slot_id,
  input  logic [31:0] time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        fired,
  output logic [3:0]  fired_slot,
  output logic        last,
  output logic        none_pending,
  output logic [31:0] next_deadline,
  output logic [31:0] time_left
);

  mtds_pkg::dp_cmd_t  cmd;
  mtds_pkg::dp_stat_t stat;

  // controller
  mtds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  mtds_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .slot_id       (slot_id),
    .time_value    (time_value),
    .cfg_we        (cfg_we),
    .min_rearm_gap (min_rearm_gap),
    .fired         (fired),
    .fired_slot    (fired_slot),
    .last          (last),
    .none_pending  (none_pending),
    .next_deadline (next_deadline),
    .time_left     (time_left)
  );

  // no word accepted while results are on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("input word accepted while a result is pending");

  // a status-only word is always the final one
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !fired) |-> last)
    else $error("non-expiry result without last");

  // nothing armed means nothing left to wait for
  a_idle_time: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_pending) |-> (time_left == 32'd0))
    else $error("time left reported with no armed slot");

  // taking the final word ends the burst
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result offered after the final word");

endmodule

>>> design/mtds_ctrl.sv
// controller state machine sequencing apply, expiry scans, earliest scan and result words
module mtds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mtds_pkg::dp_stat_t stat,
  output mtds_pkg::dp_cmd_t  cmd
);

  mtds_pkg::state_t state;
  mtds_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != mtds_pkg::ST_IDLE);
  assign out_valid = (state == mtds_pkg::ST_OUT);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mtds_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mtds_pkg::ST_APPLY;
        end
      end
      mtds_pkg::ST_APPLY: begin
        cmd.apply      = 1'b1;
        cmd.scan_clear = 1'b1;
        state_next     = stat.is_tick ? mtds_pkg::ST_PICK : mtds_pkg::ST_FIND;
      end
      mtds_pkg::ST_PICK: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = mtds_pkg::ST_FIRE;
        end
      end
      mtds_pkg::ST_FIRE: begin
        cmd.scan_clear = 1'b1;
        if (stat.found) begin
          cmd.fire   = 1'b1;
          state_next = stat.room ? mtds_pkg::ST_PICK : mtds_pkg::ST_FIND;
        end else begin
          state_next = mtds_pkg::ST_FIND;
        end
      end
      mtds_pkg::ST_FIND: begin
        cmd.scan = 1'b1;
        cmd.find = 1'b1;
        if (stat.scan_last) begin
          state_next = mtds_pkg::ST_OUT;
        end
      end
      mtds_pkg::ST_OUT: begin
        if (!out_stall) begin
          cmd.out_next = 1'b1;
          if (stat.out_last) begin
            state_next = mtds_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = mtds_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/mtds_dp.sv
// datapath: deadline table, time registers, shared scan unit and fired-slot list
module mtds_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  mtds_pkg::dp_cmd_t       cmd,
  output mtds_pkg::dp_stat_t      stat,
  input  logic [1:0]              mode,
  input  logic [3:0]              slot_id,
  input  logic [31:0]             time_value,
  input  logic                    cfg_we,
  input  logic [7:0]              min_rearm_gap,
  output logic                    fired,
  output logic [3:0]              fired_slot,
  output logic                    last,
  output logic                    none_pending,
  output logic [31:0]             next_deadline,
  output logic [31:0]             time_left
);

  localparam int TB = mtds_pkg::TIME_BITS;
  localparam int SB = mtds_pkg::SLOT_BITS;
  localparam int CB = mtds_pkg::CNT_BITS;
  localparam int FB = mtds_pkg::FL_BITS;

  logic [TB-1:0]                  table_q [mtds_pkg::NUM_SLOTS];
  logic [TB-1:0]                  cur_time;
  logic [TB-1:0]                  earliest;
  logic [mtds_pkg::GAP_BITS-1:0]  gap;
  logic [1:0]                     mode_q;
  logic [3:0]                     slot_q;
  logic [TB-1:0]                  tv_q;
  logic [SB-1:0]                  scan_idx;
  logic                           best_found;
  logic [SB-1:0]                  best_idx;
  logic [TB-1:0]                  best_val;
  logic [3:0]                     fire_list [mtds_pkg::FIRE_LIMIT];
  logic [CB-1:0]                  fire_cnt;
  logic [CB-1:0]                  out_idx;

  logic [TB-1:0]                  scan_d;
  logic                           take;
  logic                           found_next;
  logic [TB-1:0]                  best_val_next;
  logic                           slot_ok;
  logic [SB-1:0]                  slot_sel;
  logic [TB:0]                    floor_sum;
  logic [TB-1:0]                  floor_t;
  logic [TB-1:0]                  rearm_val;
  logic [TB-1:0]                  left_val;

  // scan candidate: due slots while picking, any armed slot while finding earliest
  assign scan_d = table_q[scan_idx];
  always_comb begin
    take = (scan_d != '0) && (!best_found || (scan_d < best_val));
    if (!cmd.find) begin
      take = take && (scan_d <= cur_time);
    end
  end
  assign found_next    = best_found | take;
  assign best_val_next = take ? scan_d : best_val;

  // slot addressing and reinstate floor with saturation
  assign slot_ok   = ((SB + 4)'(slot_q) < (SB + 4)'(mtds_pkg::NUM_SLOTS));
  assign slot_sel  = SB'(slot_q);
  assign floor_sum = (TB + 1)'(cur_time) + (TB + 1)'(gap);
  assign floor_t   = floor_sum[TB] ? '1 : floor_sum[TB-1:0];
  assign rearm_val = (tv_q == '0) ? '0 : ((floor_t > tv_q) ? floor_t : tv_q);

  // latched input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      slot_q <= slot_id;
      tv_q   <= TB'(time_value);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= mtds_pkg::GAP_BITS'(mtds_pkg::GAP_RESET);
    end else if (cfg_we) begin
      gap <= min_rearm_gap;
    end
  end

  // deadline table and current time
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mtds_pkg::NUM_SLOTS; i++) begin
        table_q[i] <= '0;
      end
      cur_time <= '0;
    end else if (cmd.apply) begin
      case (mode_q)
        mtds_pkg::MODE_SCHED: begin
          if (slot_ok) begin
            table_q[slot_sel] <= tv_q;
          end
        end
        mtds_pkg::MODE_TICK: begin
          cur_time <= tv_q;
        end
        mtds_pkg::MODE_REINST: begin
          if (slot_ok) begin
            table_q[slot_sel] <= rearm_val;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.fire) begin
      table_q[best_idx] <= '0;
    end
  end

  // shared scan unit, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
    end else if (cmd.scan) begin
      scan_idx   <= stat.scan_last ? '0 : scan_idx + SB'(1);
      best_found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      best_val <= best_val_next;
      if (take) begin
        best_idx <= scan_idx;
      end
    end
  end

  // earliest armed deadline, written at the end of the find scan
  always_ff @(posedge clk) begin
    if (rst) begin
      earliest <= '0;
    end else if (cmd.scan && cmd.find && stat.scan_last) begin
      earliest <= found_next ? best_val_next : '0;
    end
  end

  // fired slot list and result counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_cnt <= '0;
      out_idx  <= '0;
    end else if (cmd.load) begin
      fire_cnt <= '0;
      out_idx  <= '0;
    end else begin
      if (cmd.fire) begin
        fire_cnt <= fire_cnt + CB'(1);
      end
      if (cmd.out_next) begin
        out_idx <= out_idx + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      fire_list[fire_cnt[FB-1:0]] <= 4'(best_idx);
    end
  end

  // status to the controller
  assign stat.is_tick   = (mode_q == mtds_pkg::MODE_TICK);
  assign stat.scan_last = (scan_idx == SB'(mtds_pkg::NUM_SLOTS - 1));
  assign stat.found     = best_found;
  assign stat.room      = (fire_cnt < CB'(mtds_pkg::FIRE_LIMIT - 1));
  assign stat.out_last  = (fire_cnt == '0) || ((out_idx + CB'(1)) == fire_cnt);

  // result word
  assign left_val      = (earliest > cur_time) ? (earliest - cur_time) : '0;
  assign fired         = (fire_cnt != '0);
  assign fired_slot    = fired ? fire_list[out_idx[FB-1:0]] : 4'd0;
  assign last          = stat.out_last;
  assign none_pending  = (earliest == '0);
  assign next_deadline = 32'(earliest);
  assign time_left     = 32'(left_val);

endmodule
